// ===== src/pstsu_pkg.sv =====
// shared types, constants and table functions of the per-step timing statistics unit
`default_nettype none
package pstsu_pkg;

   // field widths
   localparam int TIME_W = 27;
   localparam int MAX_W  = 28;
   localparam int RT_W   = 31;
   localparam int Q_W    = 35;
   localparam int CSR_W  = 32;
   localparam int FRAC_W = 33;

   // parameter defaults
   localparam int STEP_COUNT_DEFAULT          = 16;
   localparam int FRACTION_TABLE_SIZE_DEFAULT = 64;

   // reset values
   localparam logic [TIME_W-1:0] LIMIT_RESET     = 27'd99999999;
   localparam logic [TIME_W-1:0] MIN_RESET       = {TIME_W{1'b1}};
   localparam logic [MAX_W-1:0]  MAX_RESET       = {MAX_W{1'b1}};
   localparam logic [15:0]       WEIGHT_RESET    = 16'd6554;
   localparam logic              MODE_RESET      = 1'b0;
   localparam logic [31:0]       LIN_RATE_RESET  = 32'd2147;
   localparam logic [31:0]       HALF_INV_RESET  = 32'd4295;

   // commands
   typedef enum logic [2:0] {
      CMD_RECORD    = 3'd0,
      CMD_SET_LIMIT = 3'd1,
      CMD_CLEAR_ALL = 3'd2,
      CMD_CLEAR_MAX = 3'd3,
      CMD_CLEAR_MIN = 3'd4
   } cmd_type;

   // register indexes
   typedef enum logic [1:0] {
      CSR_AVERAGE_WEIGHT    = 2'd0,
      CSR_DECAY_MODE        = 2'd1,
      CSR_LINEAR_DECAY_RATE = 2'd2,
      CSR_HALF_LIFE_INVERSE = 2'd3
   } csr_index_type;

   // decay modes
   localparam logic DECAY_LINEAR = 1'b0;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL1,
      ST_FACT,
      ST_MUL2,
      ST_DONE
   } state_type;

   // one table entry
   typedef struct packed {
      logic [TIME_W-1:0] last;
      logic [TIME_W-1:0] limit;
      logic [MAX_W-1:0]  maxv;
      logic [TIME_W-1:0] minv;
      logic [Q_W-1:0]    avg;
      logic [Q_W-1:0]    peak;
   } entry_type;

   // integer square root, elaboration use only
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] rem;
      logic [63:0] bit_v;
      int i;
      rem   = x;
      r     = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (i = 0; i < 32; i++) begin
         if (bit_v > rem) bit_v = bit_v >> 2;
      end
      for (i = 0; i < 32; i++) begin
         if (bit_v != 64'd0) begin
            if (rem >= r + bit_v) begin
               rem = rem - (r + bit_v);
               r   = (r >> 1) + bit_v;
            end else begin
               r = r >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return r;
   endfunction

   // power of one half table entry k for l fraction bits, Q1.32 with one exact
   function automatic logic [FRAC_W-1:0] frac_entry(input int k, input int l);
      logic [63:0] m;
      logic [63:0] root;
      int j;
      m    = 64'h1_0000_0000;
      root = isqrt64(64'h8000_0000_0000_0000);
      for (j = 0; j < 16; j++) begin
         if (j < l) begin
            if (((k >> (l - 1 - j)) & 1) != 0) m = (m * root) >> 32;
            root = isqrt64(root << 32);
         end
      end
      return m[FRAC_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== src/per_step_timing_statistics_unit.sv =====
// Per-step timing statistics table: one entry per step with last, min, max,
// moving average and decaying peak, plus the round-trip sum over all steps.
// Items are handled one at a time: each passes through the read, first multiply,
// factor, second multiply and done states before its result is loaded into the
// output register; done waits while an earlier result is still untaken, and the
// next item is accepted only back in idle. The read-modify-write of the entry
// memory around two dependent multiplies of the peak decay (round trip times
// rate, then peak times factor) sets this sequence. The next item is accepted
// while a result still waits in the output register. Clear commands take effect
// at once through per-entry valid bits, so there is no clearing pass after reset.
`default_nettype none
module per_step_timing_statistics_unit #(
   parameter int STEP_COUNT          = pstsu_pkg::STEP_COUNT_DEFAULT,
   parameter int FRACTION_TABLE_SIZE = pstsu_pkg::FRACTION_TABLE_SIZE_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input channel
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [2:0]                    req_command,
   input  wire logic [3:0]                    req_step,
   input  wire logic [pstsu_pkg::TIME_W-1:0]  req_value,
   // result channel
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_too_long,
   output      logic [pstsu_pkg::TIME_W-1:0]  rsp_last_time,
   output      logic [pstsu_pkg::TIME_W-1:0]  rsp_min_time,
   output      logic [pstsu_pkg::MAX_W-1:0]   rsp_max_time,
   output      logic [pstsu_pkg::TIME_W-1:0]  rsp_average_time,
   output      logic [pstsu_pkg::TIME_W-1:0]  rsp_peak_time,
   output      logic [pstsu_pkg::RT_W-1:0]    rsp_round_trip,
   // configuration port
   input  wire logic                          csr_write_enable,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [pstsu_pkg::CSR_W-1:0]   csr_write_data
);

   localparam int IdxW      = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
   localparam int FracBits  = $clog2(FRACTION_TABLE_SIZE + 1) - 1;
   localparam int TableSize = 1 << FracBits;

   typedef logic [pstsu_pkg::FRAC_W-1:0] frac_table_type [TableSize];

   function automatic frac_table_type build_table();
      frac_table_type t;
      int k;
      for (k = 0; k < TableSize; k++) begin
         t[k] = pstsu_pkg::frac_entry(k, FracBits);
      end
      return t;
   endfunction

   localparam frac_table_type FracTable = build_table();

   // configuration registers
   logic [15:0] weight_ff;
   logic        mode_ff;
   logic [31:0] lin_rate_ff;
   logic [31:0] half_inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff   <= pstsu_pkg::WEIGHT_RESET;
         mode_ff     <= pstsu_pkg::MODE_RESET;
         lin_rate_ff <= pstsu_pkg::LIN_RATE_RESET;
         half_inv_ff <= pstsu_pkg::HALF_INV_RESET;
      end else if (csr_write_enable) begin
         unique case (pstsu_pkg::csr_index_type'(csr_index))
            pstsu_pkg::CSR_AVERAGE_WEIGHT:    weight_ff   <= csr_write_data[15:0];
            pstsu_pkg::CSR_DECAY_MODE:        mode_ff     <= csr_write_data[0];
            pstsu_pkg::CSR_LINEAR_DECAY_RATE: lin_rate_ff <= csr_write_data;
            pstsu_pkg::CSR_HALF_LIFE_INVERSE: half_inv_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // sequencer
   pstsu_pkg::state_type state_ff, state_in;
   logic accept;
   logic done_fire;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pstsu_pkg::ST_IDLE: if (accept) state_in = pstsu_pkg::ST_READ;
         pstsu_pkg::ST_READ: state_in = pstsu_pkg::ST_MUL1;
         pstsu_pkg::ST_MUL1: state_in = pstsu_pkg::ST_FACT;
         pstsu_pkg::ST_FACT: state_in = pstsu_pkg::ST_MUL2;
         pstsu_pkg::ST_MUL2: state_in = pstsu_pkg::ST_DONE;
         pstsu_pkg::ST_DONE: if (done_fire) state_in = pstsu_pkg::ST_IDLE;
         default:            state_in = pstsu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == pstsu_pkg::ST_IDLE);
      done_fire = (state_ff == pstsu_pkg::ST_DONE) && (!rsp_valid || rsp_ready);
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pstsu_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // latched request beat
   logic [2:0]                   cmd_ff;
   logic [pstsu_pkg::TIME_W-1:0] t_ff;
   logic [IdxW-1:0]              idx_ff;
   logic                         hit_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         t_ff   <= req_value;
         idx_ff <= IdxW'(req_step);
         hit_ff <= ({5'd0, req_step} < 9'(STEP_COUNT));
      end
   end

   // entry memory and valid bits
   pstsu_pkg::entry_type mem [STEP_COUNT];
   pstsu_pkg::entry_type rd_ff;
   pstsu_pkg::entry_type new_entry;
   logic                 mem_we;

   always_ff @(posedge clock) begin
      if (mem_we) mem[idx_ff] <= new_entry;
      if (accept) rd_ff <= mem[IdxW'(req_step)];
   end

   logic [STEP_COUNT-1:0] vmain_ff, vmax_ff, vmin_ff, vlim_ff;
   logic                  is_rec, is_clr_all, is_clr_max, is_clr_min;

   assign is_rec     = (cmd_ff == pstsu_pkg::CMD_RECORD);
   assign is_clr_all = (cmd_ff == pstsu_pkg::CMD_CLEAR_ALL);
   assign is_clr_max = (cmd_ff == pstsu_pkg::CMD_CLEAR_MAX);
   assign is_clr_min = (cmd_ff == pstsu_pkg::CMD_CLEAR_MIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         vmain_ff <= '0;
         vmax_ff  <= '0;
         vmin_ff  <= '0;
         vlim_ff  <= '0;
      end else if (done_fire) begin
         if (mem_we) begin
            vmain_ff[idx_ff] <= 1'b1;
            vmax_ff[idx_ff]  <= 1'b1;
            vmin_ff[idx_ff]  <= 1'b1;
            vlim_ff[idx_ff]  <= 1'b1;
         end
         if (is_clr_all) vmain_ff <= '0;
         if (is_clr_all || is_clr_max) vmax_ff <= '0;
         if (is_clr_all || is_clr_min) vmin_ff <= '0;
      end
   end

   // read stage: entry as seen after clears, new round-trip sum, average products
   pstsu_pkg::entry_type         eff, eff_ff;
   logic [pstsu_pkg::RT_W-1:0]   rt_ff, rtn_ff;
   logic [51:0]                  pa_ff;
   logic [50:0]                  pb_ff;
   logic [pstsu_pkg::Q_W-1:0]    tq;

   assign tq = {t_ff, 8'd0};

   always_comb begin
      eff.last  = vmain_ff[idx_ff] ? rd_ff.last  : '0;
      eff.avg   = vmain_ff[idx_ff] ? rd_ff.avg   : '0;
      eff.peak  = vmain_ff[idx_ff] ? rd_ff.peak  : '0;
      eff.maxv  = vmax_ff[idx_ff]  ? rd_ff.maxv  : pstsu_pkg::MAX_RESET;
      eff.minv  = vmin_ff[idx_ff]  ? rd_ff.minv  : pstsu_pkg::MIN_RESET;
      eff.limit = vlim_ff[idx_ff]  ? rd_ff.limit : pstsu_pkg::LIMIT_RESET;
   end

   always_ff @(posedge clock) begin
      if (state_ff == pstsu_pkg::ST_READ) begin
         eff_ff <= eff;
         rtn_ff <= rt_ff + pstsu_pkg::RT_W'(t_ff) - pstsu_pkg::RT_W'(eff.last);
         pa_ff  <= eff.avg * (17'h10000 - {1'b0, weight_ff});
         pb_ff  <= tq * weight_ff;
      end
   end

   // first multiply: round trip times decay rate, average sum
   logic [62:0]               d_ff;
   logic [pstsu_pkg::Q_W-1:0] avg_new_ff;
   logic [52:0]               avg_sum;

   assign avg_sum = {1'b0, pa_ff} + {2'b0, pb_ff} + 53'd32768;

   always_ff @(posedge clock) begin
      if (state_ff == pstsu_pkg::ST_MUL1) begin
         d_ff       <= rtn_ff * ((mode_ff == pstsu_pkg::DECAY_LINEAR) ? lin_rate_ff
                                                                      : half_inv_ff);
         avg_new_ff <= avg_sum[50:16];
      end
   end

   // factor stage: linear fraction or table entry, shift and zero flag
   logic [pstsu_pkg::FRAC_W-1:0] f_ff;
   logic [5:0]                   shift_ff;
   logic                         zero_ff;

   always_ff @(posedge clock) begin
      if (state_ff == pstsu_pkg::ST_FACT) begin
         if (mode_ff == pstsu_pkg::DECAY_LINEAR) begin
            f_ff     <= {1'b0, d_ff[31:0]};
            shift_ff <= '0;
            zero_ff  <= (d_ff[62:32] != '0);
         end else begin
            f_ff     <= FracTable[d_ff[31 -: FracBits]];
            shift_ff <= d_ff[37:32];
            zero_ff  <= (d_ff[62:38] != '0);
         end
      end
   end

   // second multiply: peak times factor
   logic [67:0] prod_ff;

   always_ff @(posedge clock) begin
      if (state_ff == pstsu_pkg::ST_MUL2) prod_ff <= eff_ff.peak * f_ff;
   end

   // final stage: decayed and raised peak, new entry
   logic [pstsu_pkg::Q_W-1:0]  scaled, decayed, peak_new;
   logic [pstsu_pkg::RT_W-1:0] rt_new;

   assign scaled = prod_ff[66:32];

   always_comb begin
      if (zero_ff)                                  decayed = '0;
      else if (mode_ff == pstsu_pkg::DECAY_LINEAR)  decayed = eff_ff.peak - scaled;
      else                                          decayed = scaled >> shift_ff;
      peak_new = (eff_ff.peak < tq) ? tq : decayed;
   end

   always_comb begin
      new_entry = eff_ff;
      rt_new    = rt_ff;
      mem_we    = 1'b0;
      unique case (cmd_ff)
         pstsu_pkg::CMD_RECORD: begin
            new_entry.last = t_ff;
            new_entry.avg  = avg_new_ff;
            new_entry.peak = peak_new;
            if ($signed({1'b0, t_ff}) > $signed(eff_ff.maxv)) new_entry.maxv = {1'b0, t_ff};
            if (t_ff < eff_ff.minv) new_entry.minv = t_ff;
            if (hit_ff) rt_new = rtn_ff;
            mem_we = hit_ff && done_fire;
         end
         pstsu_pkg::CMD_SET_LIMIT: begin
            new_entry.limit = t_ff;
            mem_we = hit_ff && done_fire;
         end
         pstsu_pkg::CMD_CLEAR_ALL: begin
            new_entry.last = '0;
            new_entry.avg  = '0;
            new_entry.peak = '0;
            new_entry.maxv = pstsu_pkg::MAX_RESET;
            new_entry.minv = pstsu_pkg::MIN_RESET;
            rt_new = '0;
         end
         pstsu_pkg::CMD_CLEAR_MAX: new_entry.maxv = pstsu_pkg::MAX_RESET;
         pstsu_pkg::CMD_CLEAR_MIN: new_entry.minv = pstsu_pkg::MIN_RESET;
         default: ;
      endcase
   end

   // round-trip sum
   always_ff @(posedge clock) begin
      if (reset)          rt_ff <= '0;
      else if (done_fire) rt_ff <= rt_new;
   end

   // output register
   logic [pstsu_pkg::Q_W:0] avg_round, peak_round;

   assign avg_round  = {1'b0, new_entry.avg}  + 36'd128;
   assign peak_round = {1'b0, new_entry.peak} + 36'd128;

   always_ff @(posedge clock) begin
      if (reset)          rsp_valid <= 1'b0;
      else if (done_fire) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_too_long     <= hit_ff && is_rec && (t_ff > eff_ff.limit);
         rsp_last_time    <= hit_ff ? new_entry.last : '0;
         rsp_min_time     <= hit_ff ? new_entry.minv : '0;
         rsp_max_time     <= hit_ff ? new_entry.maxv : '0;
         rsp_average_time <= hit_ff ? avg_round[34:8] : '0;
         rsp_peak_time    <= hit_ff ? peak_round[34:8] : '0;
         rsp_round_trip   <= rt_new;
      end
   end

endmodule
`default_nettype wire
